// ===== hw/rtl/tfai_pkg.sv =====
// Shared types, constants and helpers of the thermal frame autoscaler.
`default_nettype none

package tfai_pkg;

   // Field widths
   localparam int PIX_W      = 16;
   localparam int IDX_W      = 8;
   localparam int GEOM_W     = 11;
   localparam int COL_W      = 10;
   localparam int SIZE_W     = 2 * GEOM_W;
   localparam int NUM_W      = PIX_W + IDX_W;
   localparam int STEP_W     = $clog2(IDX_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Frame buffer sizing
   localparam int MAX_PIXELS = 131072;
   localparam int ADDR_W     = $clog2(MAX_PIXELS);
   localparam int CNT_W      = ADDR_W + 1;

   // Job queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QLVL_W = QPTR_W + 1;

   // Scaling and geometry constants
   localparam logic [IDX_W-1:0]  INDEX_TOP = IDX_W'(239);
   localparam logic [GEOM_W-1:0] GEOM_MIN  = GEOM_W'(1);
   localparam logic [GEOM_W-1:0] GEOM_MAX  = GEOM_W'(1024);
   localparam logic [PIX_W-1:0]  PIX_TOP   = '1;

   // Register reset values
   localparam logic [PIX_W-1:0]  FIXED_MIN_RST = PIX_W'(800);
   localparam logic [PIX_W-1:0]  FIXED_MAX_RST = PIX_W'(1200);
   localparam logic [GEOM_W-1:0] WIDTH_RST     = GEOM_W'(160);
   localparam logic [GEOM_W-1:0] HEIGHT_RST    = GEOM_W'(120);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DYNAMIC   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_MIN = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_MAX = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = CSR_IDX_W'(4);

   // Item kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EMIT = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [PIX_W-1:0] pixel_value;
   } tfai_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] color_index;
      logic             row_end;
      logic             frame_end;
   } tfai_rsp_type;

   // One emit job: the buffered pixel, its bounds and its flags
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] hi;
      logic             row_end;
      logic             frame_end;
   } tfai_job_type;

   // Zero acts as one, anything above the limit as the limit
   function automatic logic [GEOM_W-1:0] clamp_dim(input logic [GEOM_W-1:0] d);
      logic [GEOM_W-1:0] r;
      r = d;
      if (d == '0) begin
         r = GEOM_MIN;
      end else if (d > GEOM_MAX) begin
         r = GEOM_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/thermal_frame_autoscale_index_core.sv =====
// Top level of the thermal frame autoscaler: front end, job queue and scaler.
//
//   port group   direction  flow control         contents
//   req_*        in         start / busy         load pixel or emit next pixel
//   rsp_*        out        rsp_strobe, 1 cycle  palette index, row and frame end
//   csr_*        in         csr_valid/csr_ready  register index and write data
//
// A load item is registered in the front end. An emit item passes the buffer
// read stage and the queue, then the scaler: one state to pick up the job, one
// to clamp and multiply, and eight restoring divide steps, one per index bit;
// a clamped pixel leaves after the first two. The scaler takes no new job
// until it has produced the last result, so the divide loop sets the sustained
// rate; busy rises while the queue and the buffer read stage together hold four jobs.
// Reset clears counters, extremes and registers; the frame buffer needs no
// clearing. Results cannot be stalled by the receiver.
`default_nettype none

module thermal_frame_autoscale_index_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire tfai_pkg::tfai_req_type             req_data,
   output logic                                    rsp_strobe,
   output tfai_pkg::tfai_rsp_type                  rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [tfai_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tfai_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tfai_pkg::*;

   logic               accept;
   logic               job_valid;
   tfai_job_type       job;
   logic               head_valid;
   tfai_job_type       head_job;
   logic               job_pop;
   logic [QLVL_W-1:0]  q_level;
   logic [QLVL_W:0]    inflight;

   // Hold off items while every queue slot is spoken for
   assign inflight = (QLVL_W+1)'(q_level) + (QLVL_W+1)'(job_valid);
   assign busy     = inflight >= (QLVL_W+1)'(QDEPTH);
   assign accept   = start && !busy;

   tfai_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_valid (job_valid),
      .job       (job)
   );

   tfai_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_valid),
      .push_job   (job),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .level      (q_level)
   );

   tfai_scaler u_scaler (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (head_valid),
      .job        (head_job),
      .job_pop    (job_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/tfai_front.sv =====
// Front end: registers, item intake, frame buffer, extremes and emit classification.
`default_nettype none

module tfai_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire tfai_pkg::tfai_req_type             req_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [tfai_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tfai_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                                    job_valid,
   output tfai_pkg::tfai_job_type                  job
);
   import tfai_pkg::*;

   // Configuration registers
   logic                dynamic_ff;
   logic [PIX_W-1:0]    fixed_min_ff;
   logic [PIX_W-1:0]    fixed_max_ff;
   logic [GEOM_W-1:0]   width_ff;
   logic [GEOM_W-1:0]   height_ff;

   // Frame state
   logic [CNT_W-1:0]    loaded_ff, loaded_in;
   logic [CNT_W-1:0]    emitted_ff, emitted_in;
   logic [COL_W-1:0]    column_ff, column_in;
   logic [PIX_W-1:0]    lowest_ff, lowest_in;
   logic [PIX_W-1:0]    highest_ff, highest_in;

   // Frame buffer, no reset
   logic [PIX_W-1:0]    pixel_store [MAX_PIXELS];
   logic [PIX_W-1:0]    rd_data_ff;

   // Emit stage
   logic                s1_valid_ff;
   logic [PIX_W-1:0]    s1_lo_ff;
   logic [PIX_W-1:0]    s1_hi_ff;
   logic                s1_row_end_ff;
   logic                s1_frame_end_ff;

   logic [GEOM_W-1:0]   width_c;
   logic [GEOM_W-1:0]   height_c;
   logic [SIZE_W-1:0]   area;
   logic [CNT_W-1:0]    frame_size;
   logic                load_ok;
   logic                emit_ok;
   logic [COL_W:0]      column_next;
   logic [CNT_W-1:0]    emit_next;
   logic                row_end;
   logic                frame_end;

   assign csr_ready = 1'b1;

   // Frame geometry
   assign width_c    = clamp_dim(width_ff);
   assign height_c   = clamp_dim(height_ff);
   assign area       = SIZE_W'(width_c) * SIZE_W'(height_c);
   assign frame_size = (area > SIZE_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS)
                                                    : area[CNT_W-1:0];

   // Classify the item
   assign load_ok = accept && (req_data.req_type == REQ_LOAD) && (loaded_ff < frame_size);
   assign emit_ok = accept && (req_data.req_type == REQ_EMIT) &&
                    (emitted_ff < loaded_ff) && (emitted_ff < CNT_W'(MAX_PIXELS));

   assign column_next = {1'b0, column_ff} + (COL_W+1)'(1);
   assign emit_next   = emitted_ff + CNT_W'(1);
   assign row_end     = column_next >= width_c;
   assign frame_end   = emit_next >= frame_size;

   // Next frame state
   always_comb begin
      loaded_in  = loaded_ff;
      emitted_in = emitted_ff;
      column_in  = column_ff;
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      if (load_ok) begin
         loaded_in = loaded_ff + CNT_W'(1);
         if (req_data.pixel_value > highest_ff) begin
            highest_in = req_data.pixel_value;
         end
         if (req_data.pixel_value < lowest_ff) begin
            lowest_in = req_data.pixel_value;
         end
      end
      if (emit_ok) begin
         emitted_in = emit_next;
         column_in  = row_end ? '0 : column_next[COL_W-1:0];
         if (frame_end) begin
            loaded_in  = '0;
            emitted_in = '0;
            column_in  = '0;
            lowest_in  = PIX_TOP;
            highest_in = '0;
         end
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dynamic_ff   <= 1'b0;
         fixed_min_ff <= FIXED_MIN_RST;
         fixed_max_ff <= FIXED_MAX_RST;
         width_ff     <= WIDTH_RST;
         height_ff    <= HEIGHT_RST;
         loaded_ff    <= '0;
         emitted_ff   <= '0;
         column_ff    <= '0;
         lowest_ff    <= PIX_TOP;
         highest_ff   <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         loaded_ff   <= loaded_in;
         emitted_ff  <= emitted_in;
         column_ff   <= column_in;
         lowest_ff   <= lowest_in;
         highest_ff  <= highest_in;
         s1_valid_ff <= emit_ok;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DYNAMIC:   dynamic_ff   <= csr_wdata[0];
               CSR_FIXED_MIN: fixed_min_ff <= csr_wdata[PIX_W-1:0];
               CSR_FIXED_MAX: fixed_max_ff <= csr_wdata[PIX_W-1:0];
               CSR_WIDTH:     width_ff     <= csr_wdata[GEOM_W-1:0];
               CSR_HEIGHT:    height_ff    <= csr_wdata[GEOM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Frame buffer write and read
   always_ff @(posedge clock) begin
      if (load_ok) begin
         pixel_store[loaded_ff[ADDR_W-1:0]] <= req_data.pixel_value;
      end
      if (emit_ok) begin
         rd_data_ff <= pixel_store[emitted_ff[ADDR_W-1:0]];
      end
   end

   // Bounds and flags held alongside the buffer read
   always_ff @(posedge clock) begin
      if (emit_ok) begin
         s1_lo_ff        <= dynamic_ff ? lowest_ff  : fixed_min_ff;
         s1_hi_ff        <= dynamic_ff ? highest_ff : fixed_max_ff;
         s1_row_end_ff   <= row_end;
         s1_frame_end_ff <= frame_end;
      end
   end

   assign job_valid     = s1_valid_ff;
   assign job.pixel     = rd_data_ff;
   assign job.lo        = s1_lo_ff;
   assign job.hi        = s1_hi_ff;
   assign job.row_end   = s1_row_end_ff;
   assign job.frame_end = s1_frame_end_ff;

`ifndef SYNTHESIS
   a_emit_behind_load: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= loaded_ff)
      else $error("emit position ran past load position");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tfai_queue.sv =====
// Short job queue between the front end and the scaler.
`default_nettype none

module tfai_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire tfai_pkg::tfai_job_type        push_job,
   input  wire logic                          pop,
   output logic                               head_valid,
   output tfai_pkg::tfai_job_type             head_job,
   output logic [tfai_pkg::QLVL_W-1:0]        level
);
   import tfai_pkg::*;

   tfai_job_type       slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QLVL_W-1:0]  level_ff;
   logic               do_pop;

   assign do_pop     = pop && (level_ff != '0);
   assign head_valid = level_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];
   assign level      = level_ff;

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         case ({push, do_pop})
            2'b10:   level_ff <= level_ff + QLVL_W'(1);
            2'b01:   level_ff <= level_ff - QLVL_W'(1);
            default: level_ff <= level_ff;
         endcase
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (level_ff < QLVL_W'(QDEPTH)) || do_pop)
      else $error("job pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tfai_scaler.sv =====
// Back end: clamps each job and divides out its palette index one bit a cycle.
`default_nettype none

module tfai_scaler (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    job_valid,
   input  wire tfai_pkg::tfai_job_type  job,
   output logic                         job_pop,
   output logic                         rsp_strobe,
   output tfai_pkg::tfai_rsp_type       rsp_data
);
   import tfai_pkg::*;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_PREP = 3'b010,
      BK_DIV  = 3'b100
   } bk_state_type;

   bk_state_type       state_ff, state_in;
   tfai_job_type       job_ff;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   dsr_ff, dsr_in;
   logic [IDX_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               strobe_ff, strobe_in;
   logic [IDX_W-1:0]   color_ff, color_in;
   logic               take_job;
   logic               fits;
   logic [PIX_W-1:0]   span;
   logic [PIX_W-1:0]   offset;

   assign span   = job_ff.hi - job_ff.lo;
   assign offset = job_ff.pixel - job_ff.lo;
   assign fits   = rem_ff >= dsr_ff;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      strobe_in = 1'b0;
      color_in  = color_ff;
      take_job  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               take_job = 1'b1;
               state_in = BK_PREP;
            end
         end
         BK_PREP: begin
            if (job_ff.pixel > job_ff.hi) begin
               color_in  = INDEX_TOP;
               strobe_in = 1'b1;
               state_in  = BK_IDLE;
            end else if ((job_ff.pixel < job_ff.lo) || (job_ff.hi == job_ff.lo)) begin
               color_in  = '0;
               strobe_in = 1'b1;
               state_in  = BK_IDLE;
            end else begin
               rem_in   = NUM_W'(INDEX_TOP) * NUM_W'(offset);
               dsr_in   = NUM_W'(span) << (IDX_W - 1);
               quo_in   = '0;
               step_in  = STEP_W'(IDX_W - 1);
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            // restoring step: one quotient bit
            rem_in = fits ? (rem_ff - dsr_ff) : rem_ff;
            quo_in = {quo_ff[IDX_W-2:0], fits};
            dsr_in = dsr_ff >> 1;
            if (step_ff == '0) begin
               color_in  = quo_in;
               strobe_in = 1'b1;
               state_in  = BK_IDLE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign job_pop = take_job;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      color_ff <= color_in;
      if (take_job) begin
         job_ff <= job;
      end
   end

   // Flags follow the job that produced them
   assign rsp_strobe           = strobe_ff;
   assign rsp_data.color_index = color_ff;
   assign rsp_data.row_end     = job_ff.row_end;
   assign rsp_data.frame_end   = job_ff.frame_end;

`ifndef SYNTHESIS
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.color_index <= INDEX_TOP))
      else $error("palette index above top");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results on consecutive cycles");
   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

// ===== verif/tfai_index_check.sv =====
// Checker for the thermal frame autoscaler: predicts palette indices and compares results.
module tfai_index_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  tfai_pkg::tfai_req_type          req_data,
   input  logic                            rsp_strobe,
   input  tfai_pkg::tfai_rsp_type          rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [tfai_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tfai_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                     pending,
   output int unsigned                     fail_count
);
   import tfai_pkg::*;

   // Shadow registers
   logic              scale_dynamic;
   logic [PIX_W-1:0]  bound_lo;
   logic [PIX_W-1:0]  bound_hi;
   logic [GEOM_W-1:0] width_reg;
   logic [GEOM_W-1:0] height_reg;

   // Shadow frame state
   logic [PIX_W-1:0]  frame_buf [MAX_PIXELS];
   int unsigned       n_loaded;
   int unsigned       n_emitted;
   logic [COL_W-1:0]  column;
   logic [PIX_W-1:0]  lowest;
   logic [PIX_W-1:0]  highest;

   // Palette indices predicted and not yet seen on the result port
   tfai_rsp_type      due_results [$];

   // Zero geometry acts as one, oversize as the limit
   function automatic int unsigned dim_of(logic [GEOM_W-1:0] d);
      if (d == '0) return GEOM_MIN;
      if (d > GEOM_MAX) return GEOM_MAX;
      return d;
   endfunction

   function automatic int unsigned pixels_per_frame();
      int unsigned n;
      n = dim_of(width_reg) * dim_of(height_reg);
      return (n > MAX_PIXELS) ? MAX_PIXELS : n;
   endfunction

   // Linear stretch of v between lo and hi onto 0..INDEX_TOP, truncated
   function automatic logic [IDX_W-1:0] palette_index(int unsigned v, int unsigned lo,
                                                      int unsigned hi);
      if (v > hi) return INDEX_TOP;
      if (v < lo) return '0;
      if (hi == lo) return '0;
      return IDX_W'((int'(INDEX_TOP) * (v - lo)) / (hi - lo));
   endfunction

   task automatic clear_frame();
      n_loaded  = 0;
      n_emitted = 0;
      column    = '0;
      lowest    = PIX_TOP;
      highest   = '0;
   endtask

   task automatic reset_shadow();
      scale_dynamic = 1'b0;
      bound_lo      = FIXED_MIN_RST;
      bound_hi      = FIXED_MAX_RST;
      width_reg     = WIDTH_RST;
      height_reg    = HEIGHT_RST;
      clear_frame();
      due_results.delete();
   endtask

   task automatic apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_DYNAMIC:   scale_dynamic = data[0];
         CSR_FIXED_MIN: bound_lo      = data[PIX_W-1:0];
         CSR_FIXED_MAX: bound_hi      = data[PIX_W-1:0];
         CSR_WIDTH:     width_reg     = data[GEOM_W-1:0];
         CSR_HEIGHT:    height_reg    = data[GEOM_W-1:0];
         default: ;
      endcase
   endtask

   // Load stores a pixel and folds it into the extremes; emit predicts one index
   task automatic take_item(tfai_req_type it);
      int unsigned  size;
      int unsigned  lo;
      int unsigned  hi;
      logic         row_done;
      logic         frame_done;
      tfai_rsp_type r;
      size = pixels_per_frame();
      if (it.req_type == REQ_LOAD) begin
         // beyond capacity the pixel is dropped
         if (n_loaded < size) begin
            frame_buf[n_loaded] = it.pixel_value;
            n_loaded++;
            if (it.pixel_value > highest) highest = it.pixel_value;
            if (it.pixel_value < lowest) lowest = it.pixel_value;
         end
      end else if (n_emitted < n_loaded) begin
         lo         = scale_dynamic ? lowest  : bound_lo;
         hi         = scale_dynamic ? highest : bound_hi;
         row_done   = (column + 1) >= dim_of(width_reg);
         frame_done = (n_emitted + 1) >= size;
         r.color_index = palette_index(frame_buf[n_emitted], lo, hi);
         r.row_end     = row_done;
         r.frame_end   = frame_done;
         due_results.push_back(r);
         n_emitted++;
         column = row_done ? '0 : column + 1'b1;
         if (frame_done) clear_frame();
      end
   endtask

   task automatic check_result(tfai_rsp_type got);
      tfai_rsp_type want;
      if (due_results.size() == 0) begin
         $error("unexpected result: color_index %0d row_end %0b frame_end %0b",
                got.color_index, got.row_end, got.frame_end);
         fail_count++;
      end else begin
         want = due_results.pop_front();
         if (got.color_index !== want.color_index) begin
            $error("color_index: expected %0d, got %0d", want.color_index, got.color_index);
            fail_count++;
         end
         if (got.row_end !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, got.row_end);
            fail_count++;
         end
         if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
            fail_count++;
         end
      end
   endtask

   initial begin
      pending    = 0;
      fail_count = 0;
   end

   // Results are checked before the item of the same edge is predicted;
   // an item sees the registers as they were before a write at its edge
   always @(posedge clock) begin
      if (reset) begin
         reset_shadow();
      end else begin
         if (rsp_strobe) check_result(rsp_data);
         if (start && !busy) take_item(req_data);
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_wdata);
      end
      pending = due_results.size();
   end

endmodule

// ===== verif/tb_thermal_frame_autoscale_index_core.sv =====
// Testbench top for the thermal frame autoscaler: stimulus, clock, reset and verdict.
module tb_thermal_frame_autoscale_index_core;
   import tfai_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   tfai_req_type          req_data;
   logic                  rsp_strobe;
   tfai_rsp_type          rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           pending;
   int unsigned           fail_count;

   int unsigned           sent;
   bit                    calm;
   int unsigned           px_lo;
   int unsigned           px_hi;

   thermal_frame_autoscale_index_core dut (.*);

   tfai_index_check u_check (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #(12 * 300000);
      $display("[thermal_frame_autoscale_index_core] ERROR");
      $finish;
   end

   // Pixel near the current range of interest, with the field extremes now and then
   function automatic logic [PIX_W-1:0] pick_px();
      int unsigned lo;
      int unsigned hi;
      int unsigned r;
      lo = (px_lo > 20) ? px_lo - 20 : 0;
      hi = (px_hi + 20 > 65535) ? 65535 : px_hi + 20;
      r  = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return PIX_TOP;
      if (r < 6) return PIX_W'($urandom_range(hi, lo));
      return PIX_W'($urandom_range(px_hi, px_lo));
   endfunction

   task automatic pause(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start                = 1'b0;
         req_data.req_type    = 1'($urandom);
         req_data.pixel_value = PIX_W'($urandom);
      end
   endtask

   // Offer one item and hold it until the block takes it
   task automatic push_item(logic kind, logic [PIX_W-1:0] px);
      if (!calm && $urandom_range(0, 3) == 0) pause($urandom_range(1, 4));
      @(negedge clock);
      start                = 1'b1;
      req_data.req_type    = kind;
      req_data.pixel_value = px;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   // Stop sending, wait for every outstanding index, then let the scaler drain
   task automatic settle();
      pause(1);
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] dyn, logic [CSR_DATA_W-1:0] lo,
                            logic [CSR_DATA_W-1:0] hi, logic [CSR_DATA_W-1:0] w,
                            logic [CSR_DATA_W-1:0] h);
      settle();
      write_reg(CSR_DYNAMIC, dyn);
      write_reg(CSR_FIXED_MIN, lo);
      write_reg(CSR_FIXED_MAX, hi);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
   endtask

   initial begin
      int unsigned           base_sent;
      int unsigned           phase_start;
      int unsigned           we;
      int unsigned           he;
      int unsigned           size;
      int unsigned           quota;
      int unsigned           style;
      int unsigned           k;
      logic [CSR_DATA_W-1:0] w_enc;
      logic [CSR_DATA_W-1:0] h_enc;
      logic [CSR_DATA_W-1:0] dyn_word;
      logic [PIX_W-1:0]      f_lo;
      logic [PIX_W-1:0]      f_hi;
      logic                  dyn;

      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_DYNAMIC;
      csr_wdata = '0;
      sent      = 0;
      calm      = 1'b0;
      px_lo     = 0;
      px_hi     = 65535;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Fixed bounds: below, above, on each bound, then a load past capacity
      // and an emit with nothing left
      configure(0, 800, 1200, 5, 1);
      push_item(REQ_LOAD, 16'd0);
      push_item(REQ_LOAD, 16'hFFFF);
      push_item(REQ_LOAD, 16'd800);
      push_item(REQ_LOAD, 16'd1200);
      push_item(REQ_LOAD, 16'd799);
      push_item(REQ_LOAD, 16'd1000);
      repeat (6) push_item(REQ_EMIT, 16'($urandom));

      // Equal bounds and zero geometry, then inverted bounds
      configure(0, 500, 500, 0, 0);
      push_item(REQ_LOAD, 16'd500);
      push_item(REQ_EMIT, 16'($urandom));
      configure(0, 2000, 1000, 0, 0);
      push_item(REQ_LOAD, 16'd1500);
      push_item(REQ_EMIT, 16'($urandom));
      push_item(REQ_LOAD, 16'd900);
      push_item(REQ_EMIT, 16'($urandom));

      // Dynamic bounds that move mid-frame, oversize width
      configure(1, 0, 16'hFFFF, 2047, 1);
      push_item(REQ_LOAD, 16'd100);
      push_item(REQ_LOAD, 16'd50);
      push_item(REQ_LOAD, 16'd300);
      push_item(REQ_EMIT, 16'($urandom));
      push_item(REQ_LOAD, 16'd20);
      push_item(REQ_EMIT, 16'($urandom));

      // Random phases, each with fresh registers written while idle
      base_sent = sent;
      while (sent - base_sent < 600) begin
         // geometry: mostly tiny frames, sometimes the full buffer
         if ($urandom_range(0, 9) == 0) begin
            we    = 1024;
            he    = 1024;
            w_enc = $urandom_range(0, 1) ? 16'd1024 : 16'($urandom_range(1025, 2047));
            h_enc = $urandom_range(0, 1) ? 16'd1024 : 16'($urandom_range(1025, 2047));
         end else begin
            we    = $urandom_range(1, 6);
            he    = $urandom_range(1, 4);
            w_enc = 16'(we);
            h_enc = 16'(he);
            if ($urandom_range(0, 7) == 0) begin
               we    = 1;
               w_enc = '0;
            end
            if ($urandom_range(0, 7) == 0) begin
               he    = 1;
               h_enc = '0;
            end
         end
         // bits above the register width are ignored
         if ($urandom_range(0, 5) == 0) w_enc[15:11] = 5'($urandom);
         if ($urandom_range(0, 5) == 0) h_enc[15:11] = 5'($urandom);
         size = we * he;
         if (size > MAX_PIXELS) size = MAX_PIXELS;

         case ($urandom_range(0, 7))
            0: begin
               f_lo = '0;
               f_hi = PIX_TOP;
            end
            1: begin
               f_lo = PIX_W'($urandom);
               f_hi = f_lo;
            end
            2: begin
               f_hi = PIX_W'($urandom_range(0, 60000));
               f_lo = f_hi + PIX_W'($urandom_range(1, 5000));
            end
            default: begin
               f_lo = PIX_W'($urandom_range(0, 60000));
               f_hi = f_lo + PIX_W'($urandom_range(1, 5000));
            end
         endcase
         dyn      = 1'($urandom);
         dyn_word = {15'h0, dyn};
         if ($urandom_range(0, 5) == 0) dyn_word = {15'($urandom), dyn};
         configure(dyn_word, f_lo, f_hi, w_enc, h_enc);

         if (dyn) begin
            px_lo = $urandom_range(0, 65000);
            px_hi = px_lo + $urandom_range(0, 500);
         end else begin
            px_lo = (f_lo < f_hi) ? f_lo : f_hi;
            px_hi = (f_lo < f_hi) ? f_hi : f_lo;
         end

         calm        = (sent - base_sent) >= 500;
         quota       = $urandom_range(20, 60);
         style       = $urandom_range(0, 9);
         phase_start = sent;
         if (style < 6) begin
            // whole frames: load then read back, now and then one too many
            while (sent - phase_start < quota) begin
               k = (size > 12) ? $urandom_range(1, 12) : size;
               if ($urandom_range(0, 7) == 0) k++;
               repeat (k) push_item(REQ_LOAD, pick_px());
               if ($urandom_range(0, 7) == 0) k++;
               repeat (k) push_item(REQ_EMIT, PIX_W'($urandom));
            end
         end else begin
            // interleaved loads and emits, or plain noise
            repeat (quota) begin
               if (style == 9) begin
                  push_item($urandom_range(0, 1) ? REQ_EMIT : REQ_LOAD, pick_px());
               end else begin
                  push_item(($urandom_range(0, 4) < 2) ? REQ_EMIT : REQ_LOAD, pick_px());
               end
            end
         end
      end

      pause(1);
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (fail_count == 0) begin
         $display("[thermal_frame_autoscale_index_core] OK");
      end else begin
         $display("[thermal_frame_autoscale_index_core] ERROR");
      end
      $finish;
   end

endmodule
